### hw/rtl/fam_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package fam_pkg;

  // Fixed-point constants of the smoothing arithmetic.
  localparam int unsigned FRAC_BITS   = 16;
  localparam logic [16:0] ALPHA_ONE   = 17'd65536;
  localparam logic [16:0] ALPHA_MIN   = 17'd655;
  localparam logic [18:0] DECAY_K_Q16 = 19'd434923;
  localparam logic [6:0]  SEEN_MAX    = 7'd127;
  localparam logic [5:0]  PERIOD_RST  = 6'd16;
  localparam logic [5:0]  PERIOD_MIN  = 6'd2;
  localparam int unsigned DIV_STEPS   = 30;
  localparam int unsigned SQR_STEPS   = 16;
  localparam int unsigned EXP_STEPS   = 16;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SETUP,
    ST_SCAN,
    ST_RANGE,
    ST_PROD,
    ST_CLASS,
    ST_DIV,
    ST_SQR,
    ST_EXPY,
    ST_EXPM,
    ST_ALPHA,
    ST_UPD1,
    ST_UPD2,
    ST_DONE
  } fam_state_t;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic       accept;
    logic       setup;
    logic       scan;
    logic       range;
    logic       prod;
    logic       classify;
    logic       div;
    logic       sqr;
    logic       expy;
    logic       expm;
    logic [3:0] idx;
    logic       alpha;
    logic       upd1;
    logic       upd2;
    logic       emit;
  } fam_cmd_t;

  // Status from the datapath to the sequencer.
  typedef struct packed {
    logic first;
    logic scan_done;
    logic need_log;
  } fam_sts_t;

  // Floor square root, evaluated at elaboration only.
  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem = v;
    res = '0;
    for (int i = 31; i >= 0; i--) begin
      bitv = 64'd1 << (2 * i);
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
    end
    return res;
  endfunction

  // Q30 factor 2^(-2^-(j+1)) built by repeated floor square roots.
  function automatic logic [30:0] root_factor(input logic [4:0] j);
    logic [63:0] c;
    c = isqrt64(64'd1 << 59);
    for (int i = 0; i < 16; i++) begin
      if (i < int'(j)) begin
        c = isqrt64(c << 30);
      end
    end
    return c[30:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/fam_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module fam_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  wire logic              out_stall,
  input  wire fam_pkg::fam_sts_t sts,
  output fam_pkg::fam_cmd_t      cmd
);

  fam_pkg::fam_state_t state_r, state_nxt;
  logic [4:0]          cnt_r, cnt_nxt;
  logic                ovalid_r, ovalid_nxt;

  // State, iteration counter and output-valid registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= fam_pkg::ST_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    ovalid_nxt = ovalid_r && out_stall;
    case (state_r)
      fam_pkg::ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = fam_pkg::ST_SETUP;
        end
      end
      fam_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = sts.first ? fam_pkg::ST_DONE : fam_pkg::ST_SCAN;
      end
      fam_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = fam_pkg::ST_RANGE;
        end
      end
      fam_pkg::ST_RANGE: begin
        cmd.range = 1'b1;
        state_nxt = fam_pkg::ST_PROD;
      end
      fam_pkg::ST_PROD: begin
        cmd.prod  = 1'b1;
        state_nxt = fam_pkg::ST_CLASS;
      end
      fam_pkg::ST_CLASS: begin
        cmd.classify = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = sts.need_log ? fam_pkg::ST_DIV : fam_pkg::ST_EXPY;
      end
      fam_pkg::ST_DIV: begin
        cmd.div = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(fam_pkg::DIV_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = fam_pkg::ST_SQR;
        end
      end
      fam_pkg::ST_SQR: begin
        cmd.sqr = 1'b1;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == 5'(fam_pkg::SQR_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = fam_pkg::ST_EXPY;
        end
      end
      fam_pkg::ST_EXPY: begin
        cmd.expy  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = fam_pkg::ST_EXPM;
      end
      fam_pkg::ST_EXPM: begin
        cmd.expm = 1'b1;
        cmd.idx  = cnt_r[3:0];
        cnt_nxt  = cnt_r + 5'd1;
        if (cnt_r == 5'(fam_pkg::EXP_STEPS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = fam_pkg::ST_ALPHA;
        end
      end
      fam_pkg::ST_ALPHA: begin
        cmd.alpha = 1'b1;
        state_nxt = fam_pkg::ST_UPD1;
      end
      fam_pkg::ST_UPD1: begin
        cmd.upd1  = 1'b1;
        state_nxt = fam_pkg::ST_UPD2;
      end
      fam_pkg::ST_UPD2: begin
        cmd.upd2  = 1'b1;
        state_nxt = fam_pkg::ST_DONE;
      end
      fam_pkg::ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!ovalid_r || !out_stall) begin
          cmd.emit   = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = fam_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = fam_pkg::ST_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != fam_pkg::ST_IDLE);
  assign out_valid = ovalid_r;

endmodule

`default_nettype wire

### hw/rtl/fam_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module fam_dp #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire fam_pkg::fam_cmd_t cmd,
  output fam_pkg::fam_sts_t      sts,
  input  wire logic [31:0]       in_bar_high,
  input  wire logic [31:0]       in_bar_low,
  input  wire logic [31:0]       in_bar_close,
  input  wire logic              in_series_start,
  input  wire logic              cfg_we,
  input  wire logic [5:0]        cfg_window_period,
  output logic [47:0]            out_smoothed_price,
  output logic [16:0]            out_smoothing_factor
);

  localparam int unsigned AW   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned DW   = ((AW > 7) ? AW : 7) + 1;
  localparam int unsigned PMAX = (HISTORY_DEPTH - 1 < 63) ? HISTORY_DEPTH - 1 : 63;

  // Persistent state.
  logic [5:0]    period_r;
  logic [AW-1:0] wp_r;
  logic [6:0]    seen_r;
  logic [47:0]   avg_r;

  // Per-bar registers.
  logic [31:0]   hi_r, lo_r, cl_r;
  logic [AW-1:0] slot_r;
  logic [6:0]    nb_r;
  logic          first_r;
  logic [5:0]    p_r;
  logic [4:0]    half_r;
  logic [6:0]    len_r;
  logic [5:0]    m_r;

  // Scan registers.
  logic [5:0]    ipos_r, rpos_r;
  logic          rvld_r;
  logic [63:0]   rdata_r;
  logic [31:0]   hh1_r, ll1_r, hh2_r, ll2_r;
  logic [31:0]   r1_r, r2_r, r3_r;

  // Arithmetic registers.
  logic [38:0]   num_r;
  logic [36:0]   den_r;
  logic          rz_r;
  logic [37:0]   rem_r, dd_r;
  logic [30:0]   x_r;
  logic [16:0]   f_r;
  logic [15:0]   fr_r;
  logic [2:0]    ip_r;
  logic [30:0]   prod_r;
  logic [16:0]   alpha_r;
  logic          ge_r;
  logic [48:0]   mhi_r;
  logic [16:0]   mlo_r;
  logic [47:0]   sp_r;
  logic [16:0]   sf_r;

  logic [63:0]   mem [HISTORY_DEPTH];

  // Root factors for the fractional power of two.
  logic [30:0]   cf [16];
  for (genvar g = 0; g < 16; g++) begin : g_cf
    localparam logic [30:0] CF = fam_pkg::root_factor(5'(g));
    assign cf[g] = CF;
  end

  // Combinational helpers.
  logic [6:0]    nb_c;
  logic [5:0]    p_c;
  logic [6:0]    len_c;
  logic          issue;
  logic [6:0]    lag;
  logic [DW-1:0] addr_w;
  logic [AW-1:0] raddr;
  logic [31:0]   rhi, rlo, hh3, ll3, r1_c, r2_c, r3_c;
  logic [38:0]   num_c;
  logic [36:0]   den_c;
  logic [38:0]   den4;
  logic [37:0]   den2;
  logic          need_log;
  logic [38:0]   rem2;
  logic          dge;
  logic [61:0]   sq;
  logic [35:0]   yp;
  logic [61:0]   pp;
  logic [31:0]   rnd, asum, ash;
  logic [4:0]    sh;
  logic [47:0]   cfx, diff;
  logic [48:0]   mhi_c;
  logic [32:0]   mlo_c;
  logic [48:0]   step;

  always_comb begin
    nb_c = in_series_start ? 7'd0 : seen_r;
    if (period_r < fam_pkg::PERIOD_MIN) begin
      p_c = fam_pkg::PERIOD_MIN;
    end else if (period_r > 6'(PMAX)) begin
      p_c = 6'(PMAX);
    end else begin
      p_c = period_r;
    end
    len_c = ((nb_r < {1'b0, p_c}) ? nb_r : {1'b0, p_c}) + 7'd1;
  end

  // Scan address: the stored bar that lies lag places before the current slot.
  always_comb begin
    issue  = ({1'b0, ipos_r} < (len_r - 7'd1));
    lag    = len_r - 7'd1 - {1'b0, ipos_r};
    addr_w = DW'(slot_r) - DW'(lag);
    if (addr_w[DW-1]) begin
      addr_w = addr_w + DW'(HISTORY_DEPTH);
    end
    raddr = addr_w[AW-1:0];
    rhi   = rdata_r[63:32];
    rlo   = rdata_r[31:0];
  end

  // Ranges of the two halves and of the whole window, and the terms of the log test.
  always_comb begin
    hh3  = (hh1_r > hh2_r) ? hh1_r : hh2_r;
    ll3  = (ll1_r < ll2_r) ? ll1_r : ll2_r;
    r1_c = (hh1_r > ll1_r) ? hh1_r - ll1_r : 32'd0;
    r2_c = (hh2_r > ll2_r) ? hh2_r - ll2_r : 32'd0;
    r3_c = (hh3 > ll3) ? hh3 - ll3 : 32'd0;
    num_c = 39'({1'b0, r1_r} + {1'b0, r2_r}) * 39'(p_r);
    den_c = 37'(half_r) * 37'(r3_r);
    den4  = {den_r, 2'b00};
    den2  = {den_r, 1'b0};
    need_log = !rz_r && (num_r < den4) && (num_r >= 39'(den2));
  end

  // Long division and log2 by squaring.
  always_comb begin
    rem2 = {rem_r, 1'b0};
    dge  = (rem2 >= 39'(dd_r));
    sq   = 62'(x_r) * 62'(x_r);
  end

  // Power of two and the average update.
  always_comb begin
    yp    = 36'(f_r) * 36'(fam_pkg::DECAY_K_Q16) + 36'd32768;
    pp    = 62'(prod_r) * 62'(cf[cmd.idx]) + (62'd1 << 29);
    sh    = 5'(ip_r) + 5'd14;
    rnd   = 32'd1 << (5'(ip_r) + 5'd13);
    asum  = 32'(prod_r) + rnd;
    ash   = asum >> sh;
    cfx   = {cl_r, 16'h0000};
    diff  = (cfx >= avg_r) ? cfx - avg_r : avg_r - cfx;
    mhi_c = 49'(alpha_r) * 49'(diff[47:16]);
    mlo_c = 33'(alpha_r) * 33'(diff[15:0]) + 33'd32768;
    step  = mhi_r + 49'(mlo_r);
  end

  // Control-like state: period register, write pointer, bar count, average, read valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= fam_pkg::PERIOD_RST;
      wp_r     <= '0;
      seen_r   <= '0;
      avg_r    <= '0;
      rvld_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        period_r <= cfg_window_period;
      end
      if (cmd.accept) begin
        wp_r   <= (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
        seen_r <= (nb_c == fam_pkg::SEEN_MAX) ? fam_pkg::SEEN_MAX : nb_c + 7'd1;
      end
      if (cmd.setup && first_r) begin
        avg_r <= {cl_r, 16'h0000};
      end
      if (cmd.upd2) begin
        avg_r <= ge_r ? 48'(avg_r + 48'(step)) : 48'(avg_r - 48'(step));
      end
      rvld_r <= cmd.scan && issue;
    end
  end

  // History memory: written on accept, read one place a cycle during the scan.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mem[wp_r] <= {in_bar_high, in_bar_low};
    end
    if (cmd.scan && issue) begin
      rdata_r <= mem[raddr];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hi_r    <= in_bar_high;
      lo_r    <= in_bar_low;
      cl_r    <= in_bar_close;
      slot_r  <= wp_r;
      nb_r    <= nb_c;
      first_r <= (nb_c == 7'd0);
    end
    if (cmd.setup) begin
      p_r    <= p_c;
      half_r <= p_c[5:1];
      len_r  <= len_c;
      m_r    <= 6'((len_c - 7'd1) >> 1);
      ipos_r <= '0;
      hh1_r  <= '0;
      ll1_r  <= '1;
      hh2_r  <= hi_r;
      ll2_r  <= lo_r;
      if (first_r) begin
        alpha_r <= fam_pkg::ALPHA_ONE;
      end
    end
    if (cmd.scan) begin
      rpos_r <= ipos_r;
      if (issue) begin
        ipos_r <= ipos_r + 6'd1;
      end
      if (rvld_r) begin
        if (rpos_r <= m_r) begin
          if (rhi > hh1_r) hh1_r <= rhi;
          if (rlo < ll1_r) ll1_r <= rlo;
        end else begin
          if (rhi > hh2_r) hh2_r <= rhi;
          if (rlo < ll2_r) ll2_r <= rlo;
        end
      end
    end
    if (cmd.range) begin
      r1_r <= r1_c;
      r2_r <= r2_c;
      r3_r <= r3_c;
    end
    if (cmd.prod) begin
      num_r <= num_c;
      den_r <= den_c;
      rz_r  <= (r1_r == 32'd0) || (r2_r == 32'd0) || (r3_r == 32'd0);
    end
    if (cmd.classify) begin
      f_r   <= (!rz_r && (num_r >= den4)) ? fam_pkg::ALPHA_ONE : 17'd0;
      rem_r <= 38'(num_r - 39'(den2));
      dd_r  <= den2;
      x_r   <= 31'd1;
    end
    if (cmd.div) begin
      rem_r <= dge ? 38'(rem2 - 39'(dd_r)) : rem2[37:0];
      x_r   <= {x_r[29:0], dge};
    end
    if (cmd.sqr) begin
      x_r <= sq[61] ? sq[61:31] : sq[60:30];
      f_r <= {f_r[15:0], sq[61]};
    end
    if (cmd.expy) begin
      fr_r   <= yp[31:16];
      ip_r   <= yp[34:32];
      prod_r <= 31'd1 << 30;
    end
    if (cmd.expm) begin
      if (fr_r[15]) begin
        prod_r <= pp[60:30];
      end
      fr_r <= {fr_r[14:0], 1'b0};
    end
    if (cmd.alpha) begin
      if (ash > 32'(fam_pkg::ALPHA_ONE)) begin
        alpha_r <= fam_pkg::ALPHA_ONE;
      end else if (ash < 32'(fam_pkg::ALPHA_MIN)) begin
        alpha_r <= fam_pkg::ALPHA_MIN;
      end else begin
        alpha_r <= ash[16:0];
      end
    end
    if (cmd.upd1) begin
      ge_r  <= (cfx >= avg_r);
      mhi_r <= mhi_c;
      mlo_r <= mlo_c[32:16];
    end
    if (cmd.emit) begin
      sp_r <= avg_r;
      sf_r <= alpha_r;
    end
  end

  assign sts.first     = first_r;
  assign sts.scan_done = !issue && !rvld_r;
  assign sts.need_log  = need_log;

  assign out_smoothed_price   = sp_r;
  assign out_smoothing_factor = sf_r;

endmodule

`default_nettype wire

### hw/rtl/fractal_adaptive_moving_average.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake           Beat
// in_       input      in_valid/in_stall   bar_high, bar_low, bar_close, series_start
// out_      output     out_valid/out_stall smoothed_price, smoothing_factor
// cfg_      input      cfg_valid/cfg_ready window_period
//
// The first bar of a series goes from setup straight to the output. Any other bar
// runs a one-read-per-cycle history scan over len = min(bars, p) + 1 places, the
// ranges and products, the 30-step divider and 16-step square loop when the log is
// needed, and the 16-step power loop, each loop on one shared multiplier path.
// Reset is synchronous on rst_n and clears the control state and the period (16).
// A stalled result waits in the output register while the next bar is taken.

module fractal_adaptive_moving_average #(
  parameter int unsigned HISTORY_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_bar_high,
  input  wire logic [31:0] in_bar_low,
  input  wire logic [31:0] in_bar_close,
  input  wire logic        in_series_start,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [47:0]      out_smoothed_price,
  output logic [16:0]      out_smoothing_factor,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_window_period
);

  fam_pkg::fam_cmd_t cmd;
  fam_pkg::fam_sts_t sts;

  assign cfg_ready = 1'b1;

  fam_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fam_dp #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_bar_high          (in_bar_high),
    .in_bar_low           (in_bar_low),
    .in_bar_close         (in_bar_close),
    .in_series_start      (in_series_start),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_window_period    (cfg_window_period),
    .out_smoothed_price   (out_smoothed_price),
    .out_smoothing_factor (out_smoothing_factor)
  );

  // A taken bar occupies the block on the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a bar was taken");

  // The smoothing factor on the output stays within its clamp.
  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_smoothing_factor >= 17'd655) && (out_smoothing_factor <= 17'd65536))
    else $error("smoothing factor out of range");

  // A new result appears only as the sequencer returns to idle.
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("result appeared while still busy");

endmodule

`default_nettype wire
